// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_MIN_BLOCK_BYTES = 128;   // power of two
    localparam int DEF_LEVELS          = 8;
    localparam int DEF_HEADER_BYTES    = 16;

    localparam int LEN_W = 14;
    localparam int LVL_W = 4;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_NO_SPACE    = 2'd1,
        STS_BAD_RELEASE = 2'd2
    } bba_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_START,
        ST_A_RD,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_A_FIN,
        ST_R_START,
        ST_R_CHK,
        ST_R_LOOP,
        ST_R_BCHK,
        ST_DONE
    } bba_state_t;

    typedef struct packed {
        logic [LEN_W-1:0] granted_offset;
        bba_status_t      status;
    } bba_result_t;

endpackage

// ----- rtl/bba_if.sv -----
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_req_if
    import bba_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [LEN_W-1:0] request_bytes;
    logic [LEN_W-1:0] payload_offset;

    modport source (output valid, operation, request_bytes, payload_offset, input ready);
    modport sink   (input valid, operation, request_bytes, payload_offset, output ready);
endinterface

interface bba_rsp_if
    import bba_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] granted_offset;
    logic [1:0]       status;

    modport source (output valid, granted_offset, status, input ready);
    modport sink   (input valid, granted_offset, status, output ready);
endinterface

// ----- rtl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bba_engine.sv -----
// ----------------------------------------------------------------------------
// bba_engine
// Sequencer: clears the memories, scans and splits for allocate, checks and
// coalesces for release, and holds the result register.
// ----------------------------------------------------------------------------
module bba_engine
    import bba_pkg::*;
#(
    parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
    parameter int LEVELS          = DEF_LEVELS,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    localparam int NODE_W         = LEVELS,
    localparam int SLOT_W         = (LEVELS > 1) ? LEVELS - 1 : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    bba_req_if.sink           req,
    bba_rsp_if.source         rsp,
    output logic              free_we,
    output logic [NODE_W-1:0] free_waddr,
    output logic              free_wdata,
    output logic [NODE_W-1:0] free_raddr,
    input  logic              free_rdata,
    output logic              alloc_we,
    output logic [SLOT_W-1:0] alloc_waddr,
    output logic [LVL_W-1:0]  alloc_wdata,
    output logic [SLOT_W-1:0] alloc_raddr,
    input  logic [LVL_W-1:0]  alloc_rdata
);

    localparam int          LOG_MIN = $clog2(MIN_BLOCK_BYTES);
    localparam logic [31:0] POOL    = 32'(MIN_BLOCK_BYTES) << (LEVELS - 1);
    localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

    bba_state_t        state_reg, state_next;
    logic [NODE_W-1:0] idx_reg, idx_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  want_reg, want_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [LEN_W-1:0]  bytes_reg, offset_reg;
    bba_result_t       res_reg, res_next;
    bba_result_t       out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [LVL_W-1:0]  want_c;
    logic [LEN_W-1:0]  start_c;
    logic [NODE_W-1:0] pos_c;
    logic [SLOT_W-1:0] aslot_c;

    function automatic logic [NODE_W-1:0] base_of(input logic [LVL_W-1:0] lvl);
        base_of = NODE_W'(1) << (TOP - lvl);
    endfunction

    always_comb
    begin
        logic [31:0] need;
        need   = 32'(bytes_reg) + 32'(HEADER_BYTES);
        want_c = LVL_W'(LEVELS);
        for (int w = LEVELS - 1; w >= 0; w--)
        begin
            if ((32'(MIN_BLOCK_BYTES) << w) >= need)
            begin
                want_c = LVL_W'(w);
            end
        end
    end

    assign start_c = offset_reg - LEN_W'(HEADER_BYTES);
    assign pos_c   = idx_reg - base_of(want_reg);
    assign aslot_c = SLOT_W'(32'(pos_c) << want_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        want_reg <= want_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (req.valid && req.ready)
        begin
            bytes_reg  <= req.request_bytes;
            offset_reg <= req.payload_offset;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lvl_next       = lvl_reg;
        want_next      = want_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        free_we        = 1'b0;
        free_waddr     = idx_reg;
        free_wdata     = 1'b0;
        free_raddr     = idx_reg;
        alloc_we       = 1'b0;
        alloc_waddr    = slot_reg;
        alloc_wdata    = '0;
        alloc_raddr    = slot_reg;
        req.ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_CLEAR:
            begin
                free_we     = 1'b1;
                free_wdata  = (idx_reg == NODE_W'(1));
                alloc_we    = 1'b1;
                alloc_waddr = SLOT_W'(idx_reg);
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.operation == OP_ALLOC) ? ST_A_START : ST_R_START;
                end
            end
            ST_A_START:
            begin
                want_next = want_c;
                lvl_next  = want_c;
                if (want_c >= LVL_W'(LEVELS))
                begin
                    res_next   = '{granted_offset: '0, status: STS_NO_SPACE};
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = base_of(want_c);
                    state_next = ST_A_RD;
                end
            end
            ST_A_RD:
            begin
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (free_rdata)
                begin
                    free_we    = 1'b1;
                    state_next = (lvl_reg > want_reg) ? ST_A_SPLIT : ST_A_FIN;
                end
                else if (idx_reg == (base_of(lvl_reg) << 1) - 1'b1)
                begin
                    if (lvl_reg == TOP)
                    begin
                        res_next   = '{granted_offset: '0, status: STS_NO_SPACE};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 1'b1;
                        idx_next   = base_of(lvl_reg) >> 1;
                        state_next = ST_A_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_A_RD;
                end
            end
            ST_A_SPLIT:
            begin
                free_we    = 1'b1;
                free_waddr = (idx_reg << 1) | NODE_W'(1);
                free_wdata = 1'b1;
                idx_next   = idx_reg << 1;
                lvl_next   = lvl_reg - 1'b1;
                if (lvl_reg - 1'b1 == want_reg)
                begin
                    state_next = ST_A_FIN;
                end
            end
            ST_A_FIN:
            begin
                alloc_we    = 1'b1;
                alloc_waddr = aslot_c;
                alloc_wdata = want_reg + 1'b1;
                res_next    = '{granted_offset:
                                LEN_W'((32'(aslot_c) << LOG_MIN) + 32'(HEADER_BYTES)),
                                status: STS_OK};
                state_next  = ST_DONE;
            end
            ST_R_START:
            begin
                slot_next   = SLOT_W'(start_c >> LOG_MIN);
                alloc_raddr = SLOT_W'(start_c >> LOG_MIN);
                if (offset_reg < LEN_W'(HEADER_BYTES) || start_c[LOG_MIN-1:0] != '0
                    || 32'(start_c) >= POOL)
                begin
                    res_next   = '{granted_offset: '0, status: STS_BAD_RELEASE};
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_R_CHK;
                end
            end
            ST_R_CHK:
            begin
                if (alloc_rdata == '0 || alloc_rdata > LVL_W'(LEVELS))
                begin
                    res_next   = '{granted_offset: '0, status: STS_BAD_RELEASE};
                    state_next = ST_DONE;
                end
                else
                begin
                    alloc_we   = 1'b1;
                    lvl_next   = alloc_rdata - 1'b1;
                    idx_next   = base_of(alloc_rdata - 1'b1)
                               + NODE_W'(slot_reg >> (alloc_rdata - 1'b1));
                    state_next = ST_R_LOOP;
                end
            end
            ST_R_LOOP:
            begin
                if (lvl_reg == TOP)
                begin
                    free_we    = 1'b1;
                    free_wdata = 1'b1;
                    res_next   = '{granted_offset: '0, status: STS_OK};
                    state_next = ST_DONE;
                end
                else
                begin
                    free_raddr = idx_reg ^ NODE_W'(1);
                    state_next = ST_R_BCHK;
                end
            end
            ST_R_BCHK:
            begin
                if (free_rdata)
                begin
                    free_we    = 1'b1;
                    free_waddr = idx_reg ^ NODE_W'(1);
                    idx_next   = idx_reg >> 1;
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = ST_R_LOOP;
                end
                else
                begin
                    free_we    = 1'b1;
                    free_wdata = 1'b1;
                    res_next   = '{granted_offset: '0, status: STS_OK};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.granted_offset = out_reg.granted_offset;
    assign rsp.status         = out_reg.status;

endmodule

// ----- rtl/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator; free map and allocation sizes held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | operation, request_bytes, payload_offset
//  rsp     | out | granted_offset, status
//
//  After reset a clearing pass over all 2**LEVELS free-map entries runs;
//  req.ready is low. One item at a time. Allocate scans tree nodes from
//  the wanted level upward, then splits down level by level; an oversized
//  request is refused. Release checks the offset, then merges with free
//  buddies level by level up to the root; a bad offset is refused. Each
//  node check waits on the registered read of the free-map RAM.
//  While rsp stalls the result register holds one item; the next item is
//  taken and worked, then waits in the done state with req.ready low.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
    parameter int LEVELS          = DEF_LEVELS,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);

    localparam int NODE_W = LEVELS;
    localparam int SLOT_W = (LEVELS > 1) ? LEVELS - 1 : 1;

    logic              free_we, free_wdata, free_rdata;
    logic [NODE_W-1:0] free_waddr, free_raddr;
    logic              alloc_we;
    logic [SLOT_W-1:0] alloc_waddr, alloc_raddr;
    logic [LVL_W-1:0]  alloc_wdata, alloc_rdata;

    bba_ram #(.WIDTH(1), .DEPTH(2 ** NODE_W)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    bba_ram #(.WIDTH(LVL_W), .DEPTH(2 ** SLOT_W)) u_alloc_ram (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (alloc_waddr),
        .wdata (alloc_wdata),
        .raddr (alloc_raddr),
        .rdata (alloc_rdata)
    );

    bba_engine #(
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .LEVELS          (LEVELS),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .free_we     (free_we),
        .free_waddr  (free_waddr),
        .free_wdata  (free_wdata),
        .free_raddr  (free_raddr),
        .free_rdata  (free_rdata),
        .alloc_we    (alloc_we),
        .alloc_waddr (alloc_waddr),
        .alloc_wdata (alloc_wdata),
        .alloc_raddr (alloc_raddr),
        .alloc_rdata (alloc_rdata)
    );

endmodule

// ----- rtl/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [LEN_W-1:0] rsp_granted_offset,
    input logic [1:0]       rsp_status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_offset)
                                    && $stable(rsp_status))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == STS_OK || rsp_status == STS_NO_SPACE
                      || rsp_status == STS_BAD_RELEASE)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STS_OK |-> rsp_granted_offset == '0)
        else $error("failed item carries an offset");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in progress");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_granted_offset (rsp.granted_offset),
    .rsp_status         (rsp.status)
);
